>>> src/uvl_pkg.sv
package uvl_pkg;

  localparam int unsigned CfgW = 16;
  localparam int unsigned IdxW = 3;
  localparam int unsigned BlinkW = 8;
  localparam int unsigned BLINK_PERIOD_DEF = 200;

  localparam logic [IdxW-1:0] REG_CLOSE_DELAY = 3'd0;
  localparam logic [IdxW-1:0] REG_SHORT_RUN = 3'd1;
  localparam logic [IdxW-1:0] REG_MEDIUM_RUN = 3'd2;
  localparam logic [IdxW-1:0] REG_LONG_RUN = 3'd3;

  localparam logic [CfgW-1:0] CLOSE_DELAY_RST = 16'd183;
  localparam logic [CfgW-1:0] SHORT_RUN_RST = 16'd10986;
  localparam logic [CfgW-1:0] MEDIUM_RUN_RST = 16'd21972;
  localparam logic [CfgW-1:0] LONG_RUN_RST = 16'd32958;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_OPEN = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_UV = 2'd3;

  localparam logic [1:0] MODE_SHORT = 2'd0;
  localparam logic [1:0] MODE_MEDIUM = 2'd1;
  localparam logic [1:0] MODE_LONG = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [7:0] KEY_PRESS_COUNT = 8'd10;
  localparam logic [3:0] COVER_LIMIT = 4'd10;
  localparam logic [BlinkW-1:0] BLINK_ON_END = 8'd30;
  localparam logic [BlinkW-1:0] BLINK_SECOND_START = 8'd60;
  localparam logic [BlinkW-1:0] BLINK_SECOND_END = 8'd90;

  typedef struct packed {
    logic       press;
    logic [7:0] hold;
    logic [3:0] open_cnt;
    logic [3:0] closed_cnt;
    logic       cover_closed;
  } deb_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [1:0]        mode;
    logic [CfgW-1:0]   elapsed;
    logic [BlinkW-1:0] blink;
  } ctl_t;

  typedef struct packed {
    logic       uv_on;
    logic       green_on;
    logic       red_on;
    logic [1:0] phase;
    logic [1:0] duration_mode;
    logic       lid_closed;
  } res_t;

endpackage

>>> src/uvl_debounce.sv
module uvl_debounce (
  input  logic          key_level,
  input  logic          tilt_level,
  input  uvl_pkg::deb_t cur,
  output uvl_pkg::deb_t nxt
);
  import uvl_pkg::*;

  always_comb begin
    nxt = cur;
    // key is active low
    if (key_level) begin
      nxt.press = 1'b0;
      nxt.hold = 8'd0;
    end else begin
      nxt.hold = cur.hold + 8'd1;
      if (cur.hold == KEY_PRESS_COUNT) nxt.press = 1'b1;
    end
    if (tilt_level) begin
      nxt.closed_cnt = 4'd0;
      if (cur.open_cnt >= COVER_LIMIT) begin
        nxt.open_cnt = COVER_LIMIT;
        nxt.cover_closed = 1'b0;
      end else begin
        nxt.open_cnt = cur.open_cnt + 4'd1;
      end
    end else begin
      nxt.open_cnt = 4'd0;
      if (cur.closed_cnt >= COVER_LIMIT) begin
        nxt.closed_cnt = COVER_LIMIT;
        nxt.cover_closed = 1'b1;
      end else begin
        nxt.closed_cnt = cur.closed_cnt + 4'd1;
      end
    end
  end

endmodule

>>> src/uvl_phase.sv
module uvl_phase #(
  parameter int unsigned BLINK_PERIOD = uvl_pkg::BLINK_PERIOD_DEF
) (
  input  logic [2:0]            overflows,
  input  logic                  cover_closed,
  input  logic                  press,
  input  logic [uvl_pkg::CfgW-1:0] close_delay,
  input  logic [uvl_pkg::CfgW-1:0] short_run,
  input  logic [uvl_pkg::CfgW-1:0] medium_run,
  input  logic [uvl_pkg::CfgW-1:0] long_run,
  input  uvl_pkg::ctl_t         cur,
  output uvl_pkg::ctl_t         nxt,
  output logic                  press_used,
  output uvl_pkg::res_t         res
);
  import uvl_pkg::*;

  localparam logic [BlinkW:0] PeriodW = (BlinkW+1)'(BLINK_PERIOD);

  logic [CfgW:0]     sum;
  logic [CfgW-1:0]   elapsed_sat;
  logic [CfgW-1:0]   run_limit;
  logic [BlinkW:0]   blink_inc;
  logic              red;
  logic              green;

  always_comb begin
    sum = {1'b0, cur.elapsed} + {{(CfgW-2){1'b0}}, overflows};
    elapsed_sat = sum[CfgW] ? {CfgW{1'b1}} : sum[CfgW-1:0];
    case (cur.mode)
      MODE_MEDIUM: run_limit = medium_run;
      MODE_LONG:   run_limit = long_run;
      default:     run_limit = short_run;
    endcase
  end

  always_comb begin
    nxt = cur;
    nxt.elapsed = elapsed_sat;
    press_used = 1'b0;
    case (cur.phase)
      PH_OPEN: begin
        if (cover_closed) begin
          nxt.elapsed = '0;
          nxt.phase = PH_WAIT;
        end else if (press) begin
          press_used = 1'b1;
          nxt.mode = (cur.mode == MODE_LONG) ? MODE_SHORT : cur.mode + 2'd1;
        end
      end
      PH_WAIT: begin
        if (elapsed_sat > close_delay) begin
          nxt.elapsed = '0;
          nxt.phase = PH_UV;
        end
      end
      PH_UV: begin
        if (elapsed_sat > run_limit) begin
          nxt.elapsed = '0;
          nxt.phase = PH_IDLE;
        end
      end
      default: begin
        if (!cover_closed) begin
          nxt.elapsed = '0;
          nxt.phase = PH_OPEN;
        end
      end
    endcase

    // lamps follow the updated phase and mode, red from the old blink count
    red = 1'b0;
    green = 1'b0;
    blink_inc = {1'b0, cur.blink} + {{BlinkW{1'b0}}, 1'b1};
    if (nxt.phase != PH_IDLE) begin
      if (nxt.mode == MODE_MEDIUM || nxt.mode == MODE_LONG) begin
        red = (cur.blink < BLINK_ON_END) ||
              ((nxt.mode == MODE_LONG) && (cur.blink >= BLINK_SECOND_START) &&
               (cur.blink < BLINK_SECOND_END));
        nxt.blink = (blink_inc >= PeriodW) ? '0 : blink_inc[BlinkW-1:0];
      end else begin
        green = 1'b1;
      end
    end

    res.uv_on = (nxt.phase == PH_UV);
    res.green_on = green;
    res.red_on = red;
    res.phase = nxt.phase;
    res.duration_mode = nxt.mode;
    res.lid_closed = cover_closed;
  end

endmodule

>>> src/uv_lid_sterilizer_controller.sv
// uv lid sterilizer controller
// input stream s_*: one word per 10 ms poll tick carrying the raw key level,
// the raw tilt level and the timer overflow count since the previous tick
// output stream m_*: one word per input word with the uv, green and red lamp
// drives, the phase, the duration mode and the debounced lid state
// config port: cfg_we writes cfg_data into register cfg_index (0 close delay,
// 1 short, 2 medium, 3 long run time); other indexes are ignored
// the result of a tick appears on m_tdata in the cycle after the word is
// accepted
// throughput: one tick per clock unless stalled; debounce, phase and lamp logic
// is a single combinational pass from the state registers into the result register
// s_tready is high whenever the result register is empty or being taken, so
// a stalled receiver holds m_tdata and blocks new input only while it stalls
// reset (rst, synchronous) returns all state to idle, short mode, open lid,
// empties the result register and restores the register defaults
module uv_lid_sterilizer_controller #(
  parameter int unsigned BLINK_PERIOD = uvl_pkg::BLINK_PERIOD_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,  // key_level, tilt_level, overflows[2:0], pad
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,  // uv_on, green_on, red_on, phase[1:0],
                                             // duration_mode[1:0], lid_closed
  input  logic                     cfg_we,
  input  logic [uvl_pkg::IdxW-1:0] cfg_index,
  input  logic [uvl_pkg::CfgW-1:0] cfg_data
);
  import uvl_pkg::*;

  logic [CfgW-1:0] close_delay;
  logic [CfgW-1:0] short_run;
  logic [CfgW-1:0] medium_run;
  logic [CfgW-1:0] long_run;

  deb_t deb;
  deb_t deb_next;
  deb_t deb_store;
  ctl_t ctl;
  ctl_t ctl_next;
  res_t res_next;
  logic press_used;
  logic accept;
  logic [7:0] out_word;

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;
  assign m_tdata = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      close_delay <= CLOSE_DELAY_RST;
      short_run <= SHORT_RUN_RST;
      medium_run <= MEDIUM_RUN_RST;
      long_run <= LONG_RUN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLOSE_DELAY: close_delay <= cfg_data;
        REG_SHORT_RUN:   short_run <= cfg_data;
        REG_MEDIUM_RUN:  medium_run <= cfg_data;
        REG_LONG_RUN:    long_run <= cfg_data;
        default: ;
      endcase
    end
  end

  uvl_debounce u_debounce (
    .key_level (s_tdata[0]),
    .tilt_level(s_tdata[1]),
    .cur       (deb),
    .nxt       (deb_next)
  );

  uvl_phase #(
    .BLINK_PERIOD(BLINK_PERIOD)
  ) u_phase (
    .overflows   (s_tdata[4:2]),
    .cover_closed(deb_next.cover_closed),
    .press       (deb_next.press),
    .close_delay (close_delay),
    .short_run   (short_run),
    .medium_run  (medium_run),
    .long_run    (long_run),
    .cur         (ctl),
    .nxt         (ctl_next),
    .press_used  (press_used),
    .res         (res_next)
  );

  // the open phase consumes the press flag when it changes mode
  always_comb begin
    deb_store = deb_next;
    if (press_used) deb_store.press = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deb <= '0;
      ctl <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        deb <= deb_store;
        ctl <= ctl_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= {res_next.lid_closed, res_next.duration_mode, res_next.phase,
                   res_next.red_on, res_next.green_on, res_next.uv_on};
    end
  end

  a_mode_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.mode != MODE_UNUSED)
    else $error("duration mode holds the unused code");

  a_blink_range: assert property (@(posedge clk) disable iff (rst)
    ctl.blink < BlinkW'(BLINK_PERIOD))
    else $error("blink counter beyond its period");

  a_cover_sat: assert property (@(posedge clk) disable iff (rst)
    deb.open_cnt <= COVER_LIMIT && deb.closed_cnt <= COVER_LIMIT)
    else $error("cover debounce counter beyond its clamp");

  a_open_to_wait: assert property (@(posedge clk) disable iff (rst)
    (ctl.phase == PH_OPEN && ctl_next.phase == PH_WAIT && accept) |=>
      (ctl.phase == PH_WAIT && deb.cover_closed && ctl.elapsed == '0))
    else $error("open to wait without a closed cover or cleared timer");

endmodule

>>> verif/tb_uv_lid_sterilizer_controller.sv
`timescale 1ns / 100ps

module tb_uv_lid_sterilizer_controller;
  import uvl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_TICKS = 400;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [7:0]      s_tdata;   // key_level, tilt_level, overflows[2:0], pad
  logic            m_tvalid;
  logic            m_tready;
  logic [7:0]      m_tdata;   // uv_on, green_on, red_on, phase[1:0],
                              // duration_mode[1:0], lid_closed
  logic            cfg_we;
  logic [IdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  uv_lid_sterilizer_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // controller state as predicted
  logic [CfgW-1:0]   close_delay, run_short, run_medium, run_long;
  logic [1:0]        phase_q, mode_q;
  logic              press_q, cover_closed_q;
  logic [7:0]        hold_cnt;
  logic [3:0]        open_cnt, closed_cnt;
  logic [CfgW-1:0]   elapsed;
  logic [BlinkW-1:0] blink;

  res_t expected_lamps[$];

  int idle_pct;
  int stall_pct;
  int cycles;
  int ticks_sent;
  int results_checked;
  int mismatches;
  int uv_runs;
  int mode_changes;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_lamps.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  function automatic res_t step_controller(logic key, logic tilt, logic [2:0] ovf);
    res_t r;
    logic [CfgW:0] sum;
    logic [CfgW-1:0] limit;
    r = '0;
    sum = elapsed + ovf;
    elapsed = (sum > {1'b0, {CfgW{1'b1}}}) ? {CfgW{1'b1}} : sum[CfgW-1:0];

    // key is active low; the flag fires when the hold count passes the threshold
    if (key) begin
      press_q = 1'b0;
      hold_cnt = '0;
    end else begin
      if (hold_cnt == KEY_PRESS_COUNT) press_q = 1'b1;
      hold_cnt = hold_cnt + 8'd1;
    end

    if (tilt) begin
      closed_cnt = '0;
      if (open_cnt == COVER_LIMIT) cover_closed_q = 1'b0;
      else open_cnt = open_cnt + 4'd1;
    end else begin
      open_cnt = '0;
      if (closed_cnt == COVER_LIMIT) cover_closed_q = 1'b1;
      else closed_cnt = closed_cnt + 4'd1;
    end

    case (mode_q)
      MODE_MEDIUM: limit = run_medium;
      MODE_LONG:   limit = run_long;
      default:     limit = run_short;
    endcase

    case (phase_q)
      PH_OPEN: begin
        if (cover_closed_q) begin
          elapsed = '0;
          phase_q = PH_WAIT;
        end else if (press_q) begin
          press_q = 1'b0;
          mode_q = (mode_q == MODE_LONG) ? MODE_SHORT : mode_q + 2'd1;
          mode_changes++;
        end
      end
      PH_WAIT: begin
        if (elapsed > close_delay) begin
          elapsed = '0;
          phase_q = PH_UV;
          uv_runs++;
        end
      end
      PH_UV: begin
        if (elapsed > limit) begin
          elapsed = '0;
          phase_q = PH_IDLE;
        end
      end
      default: begin
        if (!cover_closed_q) begin
          elapsed = '0;
          phase_q = PH_OPEN;
        end
      end
    endcase

    if (phase_q != PH_IDLE) begin
      if (mode_q == MODE_MEDIUM || mode_q == MODE_LONG) begin
        r.red_on = (blink < BLINK_ON_END) ||
                   (mode_q == MODE_LONG && blink >= BLINK_SECOND_START &&
                    blink < BLINK_SECOND_END);
        if (int'(blink) + 1 >= BLINK_PERIOD_DEF) blink = '0;
        else blink = blink + 1'b1;
      end else begin
        r.green_on = 1'b1;
      end
    end

    r.uv_on = (phase_q == PH_UV);
    r.phase = phase_q;
    r.duration_mode = mode_q;
    r.lid_closed = cover_closed_q;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_lamps.push_back(step_controller(s_tdata[0], s_tdata[1], s_tdata[4:2]));
      end
      if (m_tvalid && m_tready) begin
        got.uv_on = m_tdata[0];
        got.green_on = m_tdata[1];
        got.red_on = m_tdata[2];
        got.phase = m_tdata[4:3];
        got.duration_mode = m_tdata[6:5];
        got.lid_closed = m_tdata[7];
        if (expected_lamps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          want = expected_lamps.pop_front();
          results_checked++;
          if (got.uv_on !== want.uv_on || got.green_on !== want.green_on ||
              got.red_on !== want.red_on || got.phase !== want.phase ||
              got.duration_mode !== want.duration_mode ||
              got.lid_closed !== want.lid_closed) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d expected: uv %0d grn %0d red %0d ph %0d md %0d lid %0d",
                       results_checked, want.uv_on, want.green_on, want.red_on,
                       want.phase, want.duration_mode, want.lid_closed);
              $display("result %0d actual:   uv %0d grn %0d red %0d ph %0d md %0d lid %0d",
                       results_checked, got.uv_on, got.green_on, got.red_on, got.phase,
                       got.duration_mode, got.lid_closed);
            end
          end
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_tick(input logic key, input logic tilt, input logic [2:0] ovf);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, ovf, tilt, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_lamps.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CLOSE_DELAY: close_delay = val;
      REG_SHORT_RUN:   run_short = val;
      REG_MEDIUM_RUN:  run_medium = val;
      REG_LONG_RUN:    run_long = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic open_lid();
    repeat (11) send_tick(1'b1, 1'b1, 3'($urandom_range(7)));
  endtask

  task automatic close_lid();
    repeat (11) send_tick(1'b1, 1'b0, 3'($urandom_range(7)));
  endtask

  task automatic press_key(input int hold);
    repeat (hold) send_tick(1'b0, 1'b1, 3'($urandom_range(7)));
    send_tick(1'b1, 1'b1, 3'($urandom_range(7)));
  endtask

  task automatic test_defaults();
    repeat (2) send_tick(1'b1, 1'b1, 3'($urandom_range(7)));
    repeat (11) send_tick(1'b1, 1'b0, 3'd7);
    // 183 ticks of close delay at seven overflows per poll
    repeat (29) send_tick(1'b1, 1'b0, 3'd7);
    settle();
  endtask

  task automatic test_register_extremes();
    // indexes past the last register must not disturb anything
    for (int k = int'(REG_LONG_RUN) + 1; k < (1 << IdxW); k++)
      write_reg(IdxW'(k), CfgW'($urandom));
    write_reg(REG_SHORT_RUN, '0);
    send_tick(1'b1, 1'b0, 3'd0);
    send_tick(1'b1, 1'b0, 3'd1);
    settle();
    write_reg(REG_CLOSE_DELAY, '0);
    write_reg(REG_MEDIUM_RUN, '0);
    write_reg(REG_LONG_RUN, {CfgW{1'b1}});
    open_lid();
    press_key(11);
    close_lid();
    send_tick(1'b1, 1'b0, 3'd0);
    send_tick(1'b1, 1'b0, 3'd1);
    send_tick(1'b1, 1'b0, 3'd0);
    send_tick(1'b1, 1'b0, 3'd1);
    open_lid();
    press_key(12);
    close_lid();
    repeat (6) send_tick(1'b1, 1'b0, 3'd7);
    settle();
    write_reg(REG_LONG_RUN, 16'd3);
    repeat (3) send_tick(1'b1, 1'b0, 3'd7);
    settle();
  endtask

  task automatic test_key_modes();
    write_reg(REG_SHORT_RUN, 16'd20);
    write_reg(REG_MEDIUM_RUN, 16'd20);
    write_reg(REG_LONG_RUN, 16'd20);
    open_lid();
    press_key(10);   // one short of the threshold, no press
    press_key(11);
    press_key(15);
    press_key(11);
    // a held key re-arms every 256 polls
    press_key(270);
    press_key(11);
    close_lid();
    // press while waiting is not consumed
    repeat (14) send_tick(1'b0, 1'b0, 3'($urandom_range(7)));
    repeat (20) send_tick(1'b1, 1'b0, 3'($urandom_range(7)));
    settle();
  endtask

  task automatic test_random();
    int pace_idle[4] = '{0, 75, 0, 32};
    int pace_stall[4] = '{0, 0, 75, 32};
    int stop_at;
    for (int p = 0; p < 4; p++) begin
      settle();
      write_reg(REG_CLOSE_DELAY, CfgW'($urandom_range(40)));
      write_reg(REG_SHORT_RUN, CfgW'($urandom_range(120)));
      write_reg(REG_MEDIUM_RUN, CfgW'($urandom_range(120)));
      write_reg(REG_LONG_RUN, ($urandom_range(3) == 0) ? {CfgW{1'b1}}
                                                      : CfgW'($urandom_range(120)));
      idle_pct = pace_idle[p];
      stall_pct = pace_stall[p];
      stop_at = ticks_sent + RANDOM_TICKS / 4;
      while (ticks_sent < stop_at) begin
        // lid opened with the odd bounce, a few presses, then closed and left
        repeat ($urandom_range(12, 30))
          send_tick(1'b1, ($urandom_range(9) != 0), 3'($urandom_range(7)));
        repeat ($urandom_range(3)) press_key($urandom_range(9, 14));
        repeat ($urandom_range(11, 16))
          send_tick(($urandom_range(7) != 0), 1'b0, 3'($urandom_range(7)));
        repeat ($urandom_range(10, 60)) begin
          if ($urandom_range(9) == 0)
            send_tick(1'($urandom), 1'($urandom), 3'($urandom_range(7)));
          else
            send_tick(($urandom_range(15) != 0), 1'b0, 3'($urandom_range(7)));
        end
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CLOSE_DELAY;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    ticks_sent = 0;
    results_checked = 0;
    mismatches = 0;
    uv_runs = 0;
    mode_changes = 0;
    close_delay = CLOSE_DELAY_RST;
    run_short = SHORT_RUN_RST;
    run_medium = MEDIUM_RUN_RST;
    run_long = LONG_RUN_RST;
    phase_q = PH_IDLE;
    mode_q = MODE_SHORT;
    press_q = 1'b0;
    cover_closed_q = 1'b0;
    hold_cnt = '0;
    open_cnt = '0;
    closed_cnt = '0;
    elapsed = '0;
    blink = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_defaults();
    test_register_extremes();
    test_key_modes();
    test_random();
    settle();
    repeat (8) @(negedge clk);

    $display("%0d poll ticks sent, %0d result words checked, four pacing phases",
             ticks_sent, results_checked);
    $display("%0d uv runs started, %0d mode changes, %0d mismatches",
             uv_runs, mode_changes, mismatches);
    if (mismatches == 0 && expected_lamps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d results never arrived", expected_lamps.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
